/* rtl/core/framed_csv_command_parser_unit_assert.svh */
// assertion macros shared by the parser modules
// both macros sample on clk and are held off while arst_n is low
`ifndef FRAMED_CSV_COMMAND_PARSER_UNIT_ASSERT_SVH
`define FRAMED_CSV_COMMAND_PARSER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/core/fcp_pkg.sv */
package fcp_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 1'b1;

	localparam logic [7:0] START_MARKER_RST = 8'd60;
	localparam logic [7:0] END_MARKER_RST   = 8'd62;

	// number of value slots on the result
	localparam int unsigned NUM_VALUES = 6;

	// depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// classified byte handed from front to back
	typedef struct packed {
		logic       is_end;
		logic       is_start;
		logic       is_comma;
		logic       is_blank;
		logic       is_sign;
		logic       is_minus;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_move;
		logic       is_report;
	} cls_t;

endpackage

/* rtl/core/fcp_front.sv */
module fcp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          rx_valid,
	output logic                          rx_ready,
	input  logic [7:0]                    rx_byte,
	input  logic                          q_full,
	output logic                          q_push,
	output fcp_pkg::cls_t                 q_data
);
	import fcp_pkg::*;

	logic [7:0] start_marker_q;
	logic [7:0] end_marker_q;

	// marker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= START_MARKER_RST;
			end_marker_q   <= END_MARKER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_MARKER: start_marker_q <= cfg_data;
				REG_END_MARKER:   end_marker_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// accept whenever the queue has room
	assign rx_ready = !q_full;
	assign q_push   = rx_valid && rx_ready;

	// byte classification
	always_comb begin
		q_data           = '0;
		q_data.is_end    = (rx_byte == end_marker_q);
		q_data.is_start  = (rx_byte == start_marker_q);
		q_data.is_comma  = (rx_byte == 8'h2C);
		q_data.is_blank  = (rx_byte == 8'h20) || (rx_byte >= 8'h09 && rx_byte <= 8'h0D);
		q_data.is_sign   = (rx_byte == 8'h2B) || (rx_byte == 8'h2D);
		q_data.is_minus  = (rx_byte == 8'h2D);
		q_data.is_digit  = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
		q_data.digit     = rx_byte[3:0];
		q_data.is_move   = (rx_byte == 8'h30);
		q_data.is_report = (rx_byte == 8'h31);
	end

endmodule

/* rtl/core/fcp_queue.sv */
module fcp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fcp_pkg::cls_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          q_valid,
	output fcp_pkg::cls_t q_data
);
	import fcp_pkg::*;
	`include "framed_csv_command_parser_unit_assert.svh"

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	cls_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_FULL);
	assign q_valid = (count_q != '0);
	assign q_data  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

	`ASSERT_NEVER(a_no_overfill, push && full, "queue written while full")
	`ASSERT_NEVER(a_no_underrun, pop && !q_valid, "queue read while empty")
	`ASSERT_CLK(a_count_up, (push && !pop) |=> (count_q == $past(count_q) + 1'b1), "count lost a push")

endmodule

/* rtl/core/fcp_back.sv */
module fcp_back #(
	parameter int unsigned FRAME_LIMIT = 64,
	parameter int unsigned MAX_VALUES  = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  fcp_pkg::cls_t      q_data,
	output logic               q_pop,
	output logic               res_valid,
	input  logic               res_ready,
	output logic               frame_kind,
	output logic [2:0]         value_count,
	output logic signed [15:0] value_0,
	output logic signed [15:0] value_1,
	output logic signed [15:0] value_2,
	output logic signed [15:0] value_3,
	output logic signed [15:0] value_4,
	output logic signed [15:0] value_5,
	output logic               truncated
);
	import fcp_pkg::*;
	`include "framed_csv_command_parser_unit_assert.svh"

	localparam int unsigned CNT_W = $clog2(FRAME_LIMIT);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAME_LIMIT - 1);
	localparam logic [2:0] TOK_MAX = 3'(MAX_VALUES);

	// frame kind codes
	localparam logic [1:0] KIND_NONE       = 2'd0;
	localparam logic [1:0] KIND_REPORT     = 2'd1;
	localparam logic [1:0] KIND_MOVE_FIRST = 2'd2;
	localparam logic [1:0] KIND_MOVE_ARGS  = 2'd3;

	// token phase codes
	localparam logic [1:0] PH_EMPTY = 2'd0;
	localparam logic [1:0] PH_BLANK = 2'd1;
	localparam logic [1:0] PH_NUM   = 2'd2;
	localparam logic [1:0] PH_END   = 2'd3;

	localparam logic [19:0] ACC_CLAMP = 20'd32768;

	logic             in_frame_q, in_frame_d;
	logic             await_q, await_d;
	logic [1:0]       kind_q, kind_d;
	logic [CNT_W-1:0] cc_q, cc_d;
	logic [2:0]       tn_q, tn_d;
	logic [1:0]       ph_q, ph_d;
	logic             neg_q, neg_d;
	logic [15:0]      acc_q, acc_d;
	logic             ovf_q, ovf_d;
	logic [15:0]      store_q [NUM_VALUES];
	logic             st_we;
	logic             st_clr;

	logic             close;
	logic             emit;
	logic             stall;
	logic             store_fin;
	logic [15:0]      sat;
	logic [19:0]      acc_ext;
	logic [19:0]      mac;
	logic [15:0]      mac_clamped;

	logic             res_valid_q;
	logic             kind_res_q;
	logic [2:0]       count_res_q;
	logic [15:0]      val_res_q [NUM_VALUES];
	logic             trunc_res_q;

	// frame close and result hand-off
	assign close = q_data.is_end && in_frame_q;
	assign emit  = close && !await_q && (kind_q != KIND_NONE);
	assign stall = emit && res_valid_q && !res_ready;
	assign q_pop = q_valid && !stall;

	// saturated value of the token in progress
	always_comb begin
		if (neg_q)
			sat = acc_q[15] ? 16'h8000 : 16'(~acc_q + 16'd1);
		else
			sat = acc_q[15] ? 16'h7FFF : acc_q;
	end

	assign store_fin = (kind_q == KIND_MOVE_ARGS) && (ph_q != PH_EMPTY) && (tn_q < TOK_MAX);

	// decimal accumulate, times ten by shift and add
	assign acc_ext     = 20'(acc_q);
	assign mac         = (acc_ext << 3) + (acc_ext << 1) + 20'(q_data.digit);
	assign mac_clamped = (mac > ACC_CLAMP) ? 16'h8000 : mac[15:0];

	// parser next state
	always_comb begin
		in_frame_d = in_frame_q;
		await_d    = await_q;
		kind_d     = kind_q;
		cc_d       = cc_q;
		tn_d       = tn_q;
		ph_d       = ph_q;
		neg_d      = neg_q;
		acc_d      = acc_q;
		ovf_d      = ovf_q;
		st_we      = 1'b0;
		st_clr     = 1'b0;
		if (q_pop) begin
			priority if (q_data.is_start) begin
				in_frame_d = 1'b1;
				await_d    = 1'b1;
				kind_d     = KIND_NONE;
				cc_d       = '0;
				tn_d       = '0;
				ph_d       = PH_EMPTY;
				neg_d      = 1'b0;
				acc_d      = '0;
				ovf_d      = 1'b0;
				st_clr     = 1'b1;
			end else if (close) begin
				in_frame_d = 1'b0;
			end else if (in_frame_q) begin
				if (cc_q >= CNT_MAX) begin
					ovf_d = 1'b1;
				end else begin
					cc_d = cc_q + 1'b1;
					if (await_q) begin
						await_d = 1'b0;
						kind_d  = q_data.is_move ? KIND_MOVE_FIRST :
						          q_data.is_report ? KIND_REPORT : KIND_NONE;
					end else if (kind_q[1]) begin
						if (q_data.is_comma) begin
							if (kind_q == KIND_MOVE_FIRST) begin
								kind_d = KIND_MOVE_ARGS;
							end else begin
								st_we = store_fin;
								tn_d  = store_fin ? tn_q + 1'b1 : tn_q;
								ph_d  = PH_EMPTY;
								neg_d = 1'b0;
								acc_d = '0;
							end
						end else if (kind_q == KIND_MOVE_ARGS) begin
							unique case (ph_q)
								PH_EMPTY, PH_BLANK: begin
									priority if (q_data.is_blank) begin
										ph_d = PH_BLANK;
									end else if (q_data.is_sign) begin
										neg_d = q_data.is_minus;
										ph_d  = PH_NUM;
									end else if (q_data.is_digit) begin
										acc_d = 16'(q_data.digit);
										ph_d  = PH_NUM;
									end else begin
										ph_d = PH_END;
									end
								end
								PH_NUM: begin
									if (q_data.is_digit)
										acc_d = mac_clamped;
									else
										ph_d = PH_END;
								end
								default: ;
							endcase
						end
					end
				end
			end else begin
				// bytes outside a frame are ignored
			end
		end
	end

	// parser control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			await_q    <= 1'b0;
			kind_q     <= KIND_NONE;
			cc_q       <= '0;
			tn_q       <= '0;
			ph_q       <= PH_EMPTY;
			neg_q      <= 1'b0;
			acc_q      <= '0;
			ovf_q      <= 1'b0;
		end else begin
			in_frame_q <= in_frame_d;
			await_q    <= await_d;
			kind_q     <= kind_d;
			cc_q       <= cc_d;
			tn_q       <= tn_d;
			ph_q       <= ph_d;
			neg_q      <= neg_d;
			acc_q      <= acc_d;
			ovf_q      <= ovf_d;
		end
	end

	// value store, cleared when a frame opens
	always_ff @(posedge clk) begin
		for (int j = 0; j < NUM_VALUES; j++) begin
			if (st_clr)
				store_q[j] <= '0;
			else if (st_we && tn_q == 3'(j))
				store_q[j] <= sat;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (q_pop && emit)
			res_valid_q <= 1'b1;
		else if (res_ready)
			res_valid_q <= 1'b0;
	end

	// output register payload, last token folded in on close
	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			kind_res_q  <= (kind_q == KIND_REPORT);
			count_res_q <= kind_q[1] ? tn_q + 3'(store_fin) : 3'd0;
			trunc_res_q <= ovf_q;
			for (int j = 0; j < NUM_VALUES; j++)
				val_res_q[j] <= (store_fin && tn_q == 3'(j)) ? sat : store_q[j];
		end
	end

	assign res_valid   = res_valid_q;
	assign frame_kind  = kind_res_q;
	assign value_count = count_res_q;
	assign value_0     = val_res_q[0];
	assign value_1     = val_res_q[1];
	assign value_2     = val_res_q[2];
	assign value_3     = val_res_q[3];
	assign value_4     = val_res_q[4];
	assign value_5     = val_res_q[5];
	assign truncated   = trunc_res_q;

	`ASSERT_CLK(a_count_limit, res_valid |-> (value_count <= TOK_MAX), "value count above limit")
	`ASSERT_CLK(a_report_empty, (res_valid && frame_kind) |-> (value_count == 3'd0), "report with values")
	`ASSERT_NEVER(a_char_limit, cc_q > CNT_MAX, "character count past frame limit")
	`ASSERT_NEVER(a_kind_await, await_q && (kind_q != KIND_NONE), "kind set before first character")

endmodule

/* rtl/core/framed_csv_command_parser_unit.sv */
// framed csv command parser
// rx channel: one byte per transaction on rx_byte with rx_valid and rx_ready.
// res channel: one transaction per closed move or report frame, carrying
// frame_kind, value_count, value_0 to value_5 and truncated.
// cfg port: cfg_we writes cfg_data to register cfg_index (0 start marker,
// 1 end marker); write only while the parser is idle.
// throughput: one byte per cycle while the parser is not stalled by a held result.
// result path: the end marker passes through the two-entry byte queue and
// then the output register before res_valid rises.
// reset: markers return to '<' and '>', no frame is open, queue and output
// register are emptied.
// stall: a held result blocks the parser only when the next closing frame
// has a result to give; the queue then fills and rx_ready drops after one
// further byte.
module framed_csv_command_parser_unit #(
	parameter int unsigned FRAME_LIMIT = 64,
	parameter int unsigned MAX_VALUES  = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          rx_valid,
	output logic                          rx_ready,
	input  logic [7:0]                    rx_byte,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic                          frame_kind,
	output logic [2:0]                    value_count,
	output logic signed [15:0]            value_0,
	output logic signed [15:0]            value_1,
	output logic signed [15:0]            value_2,
	output logic signed [15:0]            value_3,
	output logic signed [15:0]            value_4,
	output logic signed [15:0]            value_5,
	output logic                          truncated
);
	import fcp_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_valid;
	cls_t push_data;
	cls_t pop_data;

	// byte intake and classification
	fcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (push_data)
	);

	// decoupling queue
	fcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.q_valid   (q_valid),
		.q_data    (pop_data)
	);

	// frame parser and output register
	fcp_back #(
		.FRAME_LIMIT (FRAME_LIMIT),
		.MAX_VALUES  (MAX_VALUES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (pop_data),
		.q_pop       (q_pop),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.frame_kind  (frame_kind),
		.value_count (value_count),
		.value_0     (value_0),
		.value_1     (value_1),
		.value_2     (value_2),
		.value_3     (value_3),
		.value_4     (value_4),
		.value_5     (value_5),
		.truncated   (truncated)
	);

endmodule
